// ===== sv/tdls_pkg.sv =====
// ----------------------------------------------------------------------------
// tdls_pkg
// Shared widths, codes, configuration and result types of the door sequencer.
// ----------------------------------------------------------------------------
package tdls_pkg;

  localparam int TIMER_WIDTH = 16;
  localparam int CMD_W       = 16;
  localparam int CFG_W       = 16;
  localparam int SPEED_W     = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int OP_W        = 2;
  // timers and 16-bit limits are compared at a common width
  localparam int CMP_W       = (TIMER_WIDTH > CFG_W) ? TIMER_WIDTH : CFG_W;

  typedef logic [TIMER_WIDTH-1:0] timer_t;
  typedef logic [CMD_W-1:0]       cmd_t;
  typedef logic [SPEED_W-1:0]     speed_t;
  typedef logic [CFG_W-1:0]       cfg_word_t;
  typedef logic [OP_W-1:0]        op_t;

  localparam timer_t TIMER_MAX = '1;

  // item operation codes
  localparam op_t OP_TICK = 2'd0;
  localparam op_t OP_APP  = 2'd1;
  localparam op_t OP_RC   = 2'd2;

  // the app uses fixed codes
  localparam cmd_t APP_OPEN_CODE  = 16'd1;
  localparam cmd_t APP_CLOSE_CODE = 16'd0;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RC_OPEN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RC_CLOSE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAF_A_SPEED = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEAF_B_SPEED = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_TICKS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_TICKS  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FLASH_TICKS  = 3'd6;

  // configuration reset values
  localparam cmd_t      RST_RC_OPEN     = 16'd1;
  localparam cmd_t      RST_RC_CLOSE    = 16'd0;
  localparam speed_t    RST_SPEED       = 8'd255;
  localparam cfg_word_t RST_OPEN_TICKS  = 16'd13000;
  localparam cfg_word_t RST_CLOSE_TICKS = 16'd15000;
  localparam cfg_word_t RST_FLASH_TICKS = 16'd750;

  typedef struct packed {
    cmd_t      rc_open_code;
    cmd_t      rc_close_code;
    speed_t    leaf_a_speed;
    speed_t    leaf_b_speed;
    cfg_word_t open_ticks;
    cfg_word_t close_ticks;
    cfg_word_t flash_ticks;
  } cfg_t;

  typedef struct packed {
    op_t  op;
    cmd_t command;
  } item_t;

  typedef struct packed {
    logic [1:0] door_phase;
    logic       leaf_a_dir;
    speed_t     leaf_a_duty;
    logic       leaf_b_dir;
    speed_t     leaf_b_duty;
    logic       lift_drv_en;
    logic       leaf_b_drv_en;
    logic       small_lights;
    logic       big_lights_off;
  } res_t;

endpackage

// ===== sv/tdls_in_if.sv =====
// ----------------------------------------------------------------------------
// tdls_in_if
// Item channel of the door sequencer: tick or command poll.
// ----------------------------------------------------------------------------
interface tdls_in_if;
  import tdls_pkg::*;

  logic valid;
  logic ready;
  op_t  op;
  cmd_t command;

  modport source (output valid, output op, output command, input ready);
  modport sink   (input valid, input op, input command, output ready);

endinterface

// ===== sv/tdls_out_if.sv =====
// ----------------------------------------------------------------------------
// tdls_out_if
// Result channel of the door sequencer: phase, motor drive and light levels.
// ----------------------------------------------------------------------------
interface tdls_out_if;
  import tdls_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] door_phase;
  logic       leaf_a_dir;
  speed_t     leaf_a_duty;
  logic       leaf_b_dir;
  speed_t     leaf_b_duty;
  logic       lift_drv_en;
  logic       leaf_b_drv_en;
  logic       small_lights;
  logic       big_lights_off;

  modport source (
    output valid, output door_phase, output leaf_a_dir, output leaf_a_duty,
    output leaf_b_dir, output leaf_b_duty, output lift_drv_en,
    output leaf_b_drv_en, output small_lights, output big_lights_off,
    input  ready
  );
  modport sink (
    input  valid, input door_phase, input leaf_a_dir, input leaf_a_duty,
    input  leaf_b_dir, input leaf_b_duty, input lift_drv_en,
    input  leaf_b_drv_en, input small_lights, input big_lights_off,
    output ready
  );

endinterface

// ===== sv/timed_door_launch_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// timed_door_launch_sequencer_top
// Four-phase door controller driven by millisecond ticks and command polls.
// ----------------------------------------------------------------------------
// in_ch carries one item per transfer: a tick (op 0) or an app / RC command
// poll (op 1 / op 2) with its command value. Each item gives exactly one
// result on out_ch: door phase, motor direction and duty, driver enables,
// small light level and the big-lights-off flag of that step.
// Registers are written through cfg_we / cfg_index / cfg_wdata; the user must
// write them only while the block is idle; the block itself does not enforce
// it. Unknown indexes are ignored. The input register feeds the phase machine,
// which loads the result register. Throughput is one item per cycle while the
// receiver keeps up; the phase machine updates once per item.
// Reset puts the door in the opened phase with motors stopped, clears timers,
// previous commands, lights and driver enables, and loads the register
// defaults. When the receiver stalls, the result register holds and one more
// item can wait in the input register before in_ch.ready drops.
// ----------------------------------------------------------------------------
module timed_door_launch_sequencer_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [tdls_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tdls_pkg::CFG_W-1:0]       cfg_wdata,
  tdls_in_if.sink                          in_ch,
  tdls_out_if.source                       out_ch
);
  import tdls_pkg::*;

  cfg_t  cfg_r;
  item_t item_r;
  logic  s1_valid_r;
  logic  out_valid_r;
  logic  adv;
  logic  ld;
  logic  in_xfer;
  res_t  res;

  assign adv          = !out_valid_r || out_ch.ready;
  assign ld           = s1_valid_r && adv;
  assign in_ch.ready  = !s1_valid_r || adv;
  assign in_xfer      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rc_open_code  <= RST_RC_OPEN;
      cfg_r.rc_close_code <= RST_RC_CLOSE;
      cfg_r.leaf_a_speed  <= RST_SPEED;
      cfg_r.leaf_b_speed  <= RST_SPEED;
      cfg_r.open_ticks    <= RST_OPEN_TICKS;
      cfg_r.close_ticks   <= RST_CLOSE_TICKS;
      cfg_r.flash_ticks   <= RST_FLASH_TICKS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RC_OPEN:      cfg_r.rc_open_code  <= cfg_wdata;
        CFG_RC_CLOSE:     cfg_r.rc_close_code <= cfg_wdata;
        CFG_LEAF_A_SPEED: cfg_r.leaf_a_speed  <= cfg_wdata[SPEED_W-1:0];
        CFG_LEAF_B_SPEED: cfg_r.leaf_b_speed  <= cfg_wdata[SPEED_W-1:0];
        CFG_OPEN_TICKS:   cfg_r.open_ticks    <= cfg_wdata;
        CFG_CLOSE_TICKS:  cfg_r.close_ticks   <= cfg_wdata;
        CFG_FLASH_TICKS:  cfg_r.flash_ticks   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_xfer)  s1_valid_r <= 1'b1;
      else if (adv) s1_valid_r <= 1'b0;
      if (ld)                out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r.op      <= in_ch.op;
      item_r.command <= in_ch.command;
    end
  end

  tdls_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .ld    (ld),
    .item  (item_r),
    .cfg   (cfg_r),
    .res_r (res)
  );

  assign out_ch.valid          = out_valid_r;
  assign out_ch.door_phase     = res.door_phase;
  assign out_ch.leaf_a_dir     = res.leaf_a_dir;
  assign out_ch.leaf_a_duty    = res.leaf_a_duty;
  assign out_ch.leaf_b_dir     = res.leaf_b_dir;
  assign out_ch.leaf_b_duty    = res.leaf_b_duty;
  assign out_ch.lift_drv_en    = res.lift_drv_en;
  assign out_ch.leaf_b_drv_en  = res.leaf_b_drv_en;
  assign out_ch.small_lights   = res.small_lights;
  assign out_ch.big_lights_off = res.big_lights_off;

endmodule

// ===== sv/tdls_core.sv =====
// ----------------------------------------------------------------------------
// tdls_core
// Door phase machine, timers and light flasher; registers one result per item.
// ----------------------------------------------------------------------------
module tdls_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           ld,
  input  tdls_pkg::item_t item,
  input  tdls_pkg::cfg_t  cfg,
  output tdls_pkg::res_t  res_r
);
  import tdls_pkg::*;

  typedef enum logic [1:0] {
    PH_OPENING = 2'd0,
    PH_OPENED  = 2'd1,
    PH_CLOSING = 2'd2,
    PH_CLOSED  = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    MM_STOP  = 2'd0,
    MM_OPEN  = 2'd1,
    MM_CLOSE = 2'd2
  } motor_t;

  phase_t phase_r, phase_nxt;
  motor_t motor_r, motor_nxt;
  cmd_t   prev_app_r, prev_app_nxt;
  cmd_t   prev_rc_r, prev_rc_nxt;
  timer_t phase_timer_r, phase_timer_nxt;
  timer_t flash_timer_r, flash_timer_nxt;
  logic   light_r, light_nxt;
  logic   drv_en_r, drv_en_nxt;
  logic   flashed;
  res_t   res_nxt;

  logic      is_app;
  cmd_t      prev_cmd;
  cmd_t      open_code;
  cmd_t      close_code;
  logic      changed;
  cfg_word_t limit;
  logic      drive;

  assign is_app     = (item.op == OP_APP);
  assign prev_cmd   = is_app ? prev_app_r : prev_rc_r;
  assign open_code  = is_app ? APP_OPEN_CODE : cfg.rc_open_code;
  assign close_code = is_app ? APP_CLOSE_CODE : cfg.rc_close_code;
  assign changed    = (item.command != prev_cmd);
  assign limit      = (phase_r == PH_OPENING) ? cfg.open_ticks : cfg.close_ticks;

  always_comb begin
    phase_nxt       = phase_r;
    motor_nxt       = motor_r;
    prev_app_nxt    = prev_app_r;
    prev_rc_nxt     = prev_rc_r;
    phase_timer_nxt = phase_timer_r;
    flash_timer_nxt = flash_timer_r;
    light_nxt       = light_r;
    drv_en_nxt      = drv_en_r;
    flashed         = 1'b0;

    unique case (item.op)
      OP_TICK: begin
        if (phase_timer_r != TIMER_MAX) phase_timer_nxt = phase_timer_r + timer_t'(1);
        if (flash_timer_r != TIMER_MAX) flash_timer_nxt = flash_timer_r + timer_t'(1);
      end
      OP_APP, OP_RC: begin
        if (is_app) prev_app_nxt = item.command;
        else        prev_rc_nxt  = item.command;
        unique case (phase_r)
          PH_CLOSED: begin
            if (changed && item.command == open_code) begin
              phase_nxt       = PH_OPENING;
              phase_timer_nxt = '0;
            end
          end
          PH_OPENED: begin
            if (changed && item.command == close_code) begin
              phase_nxt       = PH_CLOSING;
              phase_timer_nxt = '0;
            end
          end
          PH_OPENING, PH_CLOSING: begin
            if (CMP_W'(phase_timer_r) < CMP_W'(limit)) begin
              motor_nxt  = (phase_r == PH_OPENING) ? MM_OPEN : MM_CLOSE;
              drv_en_nxt = 1'b1;
              flashed    = 1'b1;
              if (CMP_W'(flash_timer_r) > CMP_W'(cfg.flash_ticks)) begin
                light_nxt       = ~light_r;
                flash_timer_nxt = '0;
              end
            end else begin
              // move is over: stop and settle in the end phase
              motor_nxt = MM_STOP;
              phase_nxt = (phase_r == PH_OPENING) ? PH_OPENED : PH_CLOSED;
              light_nxt = 1'b0;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign drive = (motor_nxt == MM_OPEN) || (motor_nxt == MM_CLOSE);

  always_comb begin
    res_nxt.door_phase     = 2'(phase_nxt);
    res_nxt.leaf_a_dir     = (motor_nxt == MM_OPEN);
    res_nxt.leaf_a_duty    = drive ? cfg.leaf_a_speed : '0;
    res_nxt.leaf_b_dir     = (motor_nxt == MM_OPEN);
    res_nxt.leaf_b_duty    = drive ? cfg.leaf_b_speed : '0;
    res_nxt.lift_drv_en    = drv_en_nxt;
    res_nxt.leaf_b_drv_en  = drv_en_nxt;
    res_nxt.small_lights   = light_nxt;
    res_nxt.big_lights_off = flashed;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_OPENED;
      motor_r       <= MM_STOP;
      prev_app_r    <= '0;
      prev_rc_r     <= '0;
      phase_timer_r <= '0;
      flash_timer_r <= '0;
      light_r       <= 1'b0;
      drv_en_r      <= 1'b0;
    end else if (ld) begin
      phase_r       <= phase_nxt;
      motor_r       <= motor_nxt;
      prev_app_r    <= prev_app_nxt;
      prev_rc_r     <= prev_rc_nxt;
      phase_timer_r <= phase_timer_nxt;
      flash_timer_r <= flash_timer_nxt;
      light_r       <= light_nxt;
      drv_en_r      <= drv_en_nxt;
      res_r         <= res_nxt;
    end
  end

  // drivers stay enabled once latched
  a_drv_latched: assert property (@(posedge clk) disable iff (!rst_n)
    drv_en_r |=> drv_en_r)
    else $error("driver enable dropped");

  // motors only run during a move
  a_motor_moving: assert property (@(posedge clk) disable iff (!rst_n)
    (motor_r != MM_STOP) |-> (phase_r == PH_OPENING || phase_r == PH_CLOSING))
    else $error("motor running outside a move");

  // warning light is dark when the door is at rest
  a_light_moving: assert property (@(posedge clk) disable iff (!rst_n)
    light_r |-> (phase_r == PH_OPENING || phase_r == PH_CLOSING))
    else $error("light on outside a move");

  // a result that flashed always drives the motors
  a_flash_drive: assert property (@(posedge clk) disable iff (!rst_n)
    (ld && flashed) |=> (res_r.leaf_a_dir == (phase_r == PH_OPENING)) && drv_en_r)
    else $error("flash step without drive");

endmodule

// ===== tb/sv/timed_door_launch_sequencer_top_tb.sv =====
// ----------------------------------------------------------------------------
// timed_door_launch_sequencer_top_tb
// Self-checking bench for the four-phase door sequencer.
// A short stimulus table comes first. It covers the unused op, the case where
// a poll repeats its last command, and a full close and open. Random phases
// follow, each with its own settings (one all-zero) and tick / poll streams
// that mostly start and finish moves. A last run uses maximum settings and
// keeps a move driving with ticks and polls. Hand-checked rows are held to
// the table, all others to an in-bench model of the phases, timers and lights.
// ----------------------------------------------------------------------------
module timed_door_launch_sequencer_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tdls_pkg::*;

  typedef enum logic [1:0] {DOOR_OPENING, DOOR_OPENED, DOOR_CLOSING, DOOR_CLOSED} door_t;
  typedef enum logic [1:0] {MOTOR_STOP, MOTOR_OPEN, MOTOR_CLOSE} motor_t;

  // op code with no function
  localparam op_t OP_SPARE = 2'd3;

  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 170;
  localparam int LONG_HOLD      = 150;
  localparam int TAIL_CYCLES    = 6;
  localparam int MAX_RUN_TICKS  = 32;
  localparam int MAX_REPORTS    = 30;

  localparam logic [CFG_IDX_W-1:0] REG_ORDER [7] = '{
    CFG_RC_OPEN, CFG_RC_CLOSE, CFG_LEAF_A_SPEED, CFG_LEAF_B_SPEED,
    CFG_OPEN_TICKS, CFG_CLOSE_TICKS, CFG_FLASH_TICKS
  };

  localparam cfg_t TABLE_CFG = '{16'hFFFF, 16'h8000, 8'hFF, 8'h01, 16'd2, 16'd3, 16'd0};
  localparam cfg_t ALL_ZERO  = '0;
  localparam cfg_t ALL_MAX   = '1;

  localparam res_t AT_OPENED  = '{door_phase: DOOR_OPENED, default: '0};
  localparam res_t AT_CLOSING = '{door_phase: DOOR_CLOSING, default: '0};
  localparam res_t NO_VALUE   = '0;

  typedef struct packed {
    op_t  op;
    cmd_t command;
    logic hand_checked;
    res_t want;
  } step_row_t;

  localparam step_row_t DIRECTED_STEPS [21] = '{
    '{OP_TICK,  16'hFFFF, 1'b1, AT_OPENED},
    '{OP_SPARE, 16'h1234, 1'b1, AT_OPENED},
    // same command as last time: no move
    '{OP_APP,   16'h0000, 1'b1, AT_OPENED},
    '{OP_RC,    16'h0000, 1'b1, AT_OPENED},
    '{OP_RC,    16'h8000, 1'b1, AT_CLOSING},
    '{OP_TICK,  16'h0000, 1'b0, NO_VALUE},
    '{OP_APP,   16'h0005, 1'b0, NO_VALUE},
    '{OP_APP,   16'h0005, 1'b0, NO_VALUE},
    '{OP_TICK,  16'h0000, 1'b0, NO_VALUE},
    '{OP_TICK,  16'h0000, 1'b0, NO_VALUE},
    '{OP_RC,    16'h0000, 1'b0, NO_VALUE},
    '{OP_RC,    16'h0000, 1'b0, NO_VALUE},
    '{OP_APP,   16'h0001, 1'b0, NO_VALUE},
    '{OP_APP,   16'h0001, 1'b0, NO_VALUE},
    '{OP_TICK,  16'hFFFF, 1'b0, NO_VALUE},
    '{OP_TICK,  16'hFFFF, 1'b0, NO_VALUE},
    '{OP_RC,    16'hFFFF, 1'b0, NO_VALUE},
    '{OP_RC,    16'hFFFF, 1'b0, NO_VALUE},
    '{OP_APP,   16'h0000, 1'b0, NO_VALUE},
    '{OP_APP,   16'h0000, 1'b0, NO_VALUE},
    '{OP_SPARE, 16'hFFFF, 1'b0, NO_VALUE}
  };

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  tdls_in_if  in_ch();
  tdls_out_if out_ch();

  timed_door_launch_sequencer_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #5 clk = ~clk;

  // door model state, starts at its reset values
  cfg_t   door_cfg = '{RST_RC_OPEN, RST_RC_CLOSE, RST_SPEED, RST_SPEED,
                       RST_OPEN_TICKS, RST_CLOSE_TICKS, RST_FLASH_TICKS};
  door_t  door_state   = DOOR_OPENED;
  motor_t motor        = MOTOR_STOP;
  cmd_t   last_app_cmd = '0;
  cmd_t   last_rc_cmd  = '0;
  timer_t phase_time   = '0;
  timer_t flash_time   = '0;
  logic   light_on     = 1'b0;
  logic   drivers_on   = 1'b0;

  res_t awaited_outputs [$];
  logic row_checked = 1'b0;
  res_t row_expect  = '0;

  int   idle_pct         = 0;
  logic long_hold_req    = 1'b0;
  int   cycle_count      = 0;
  int   mismatches       = 0;
  int   outputs_checked  = 0;
  int   items_sent       = 0;
  int   moves_done       = 0;
  int   toggles          = 0;
  int   settings_applied = 0;

  function automatic logic poll_door(input cmd_t cmd, input cmd_t prev_cmd,
                                     input cmd_t open_code, input cmd_t close_code);
    cfg_word_t limit;
    logic      flashed;
    flashed = 1'b0;
    case (door_state)
      DOOR_CLOSED: if (cmd != prev_cmd && cmd == open_code) begin
        door_state = DOOR_OPENING;
        phase_time = '0;
      end
      DOOR_OPENED: if (cmd != prev_cmd && cmd == close_code) begin
        door_state = DOOR_CLOSING;
        phase_time = '0;
      end
      default: begin
        limit = (door_state == DOOR_OPENING) ? door_cfg.open_ticks : door_cfg.close_ticks;
        if (phase_time < limit) begin
          if (door_state == DOOR_OPENING) motor = MOTOR_OPEN;
          else motor = MOTOR_CLOSE;
          drivers_on = 1'b1;
          flashed = 1'b1;
          if (flash_time > door_cfg.flash_ticks) begin
            light_on = ~light_on;
            flash_time = '0;
            toggles++;
          end
        end else begin
          motor = MOTOR_STOP;
          if (door_state == DOOR_OPENING) door_state = DOOR_OPENED;
          else door_state = DOOR_CLOSED;
          light_on = 1'b0;
          moves_done++;
        end
      end
    endcase
    return flashed;
  endfunction

  function automatic res_t advance_door(input op_t op, input cmd_t cmd);
    res_t r;
    logic flashed;
    flashed = 1'b0;
    case (op)
      OP_TICK: begin
        if (phase_time != TIMER_MAX) phase_time++;
        if (flash_time != TIMER_MAX) flash_time++;
      end
      OP_APP: begin
        flashed = poll_door(cmd, last_app_cmd, APP_OPEN_CODE, APP_CLOSE_CODE);
        last_app_cmd = cmd;
      end
      OP_RC: begin
        flashed = poll_door(cmd, last_rc_cmd, door_cfg.rc_open_code, door_cfg.rc_close_code);
        last_rc_cmd = cmd;
      end
      default: ;
    endcase
    r = '0;
    r.door_phase = door_state;
    if (motor == MOTOR_OPEN || motor == MOTOR_CLOSE) begin
      r.leaf_a_dir  = (motor == MOTOR_OPEN);
      r.leaf_b_dir  = (motor == MOTOR_OPEN);
      r.leaf_a_duty = door_cfg.leaf_a_speed;
      r.leaf_b_duty = door_cfg.leaf_b_speed;
    end
    r.lift_drv_en    = drivers_on;
    r.leaf_b_drv_en  = drivers_on;
    r.small_lights   = light_on;
    r.big_lights_off = flashed;
    return r;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    if ($urandom_range(99) >= idle_pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(12, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic cfg_t pick_settings();
    cfg_t c;
    c.rc_open_code  = cmd_t'($urandom);
    c.rc_close_code = ($urandom_range(5) == 0) ? c.rc_open_code : cmd_t'($urandom);
    c.leaf_a_speed  = speed_t'($urandom);
    c.leaf_b_speed  = speed_t'($urandom);
    c.open_ticks    = cfg_word_t'($urandom_range(24));
    c.close_ticks   = cfg_word_t'($urandom_range(24));
    c.flash_ticks   = cfg_word_t'($urandom_range(6));
    return c;
  endfunction

  // biased toward polls that start a move when at rest, ticks while moving
  function automatic void pick_item(output op_t op, output cmd_t cmd);
    int   roll;
    logic use_rc;
    logic at_rest;
    cmd_t wanted;
    cmd_t prev_cmd;
    roll    = $urandom_range(99);
    use_rc  = 1'($urandom_range(1));
    at_rest = (door_state == DOOR_OPENED || door_state == DOOR_CLOSED);
    if (roll < 6) begin
      op  = op_t'($urandom_range(3));
      cmd = cmd_t'($urandom);
    end else if (roll < (at_rest ? 35 : 55)) begin
      op  = OP_TICK;
      cmd = cmd_t'($urandom);
    end else begin
      op = use_rc ? OP_RC : OP_APP;
      if (use_rc) begin
        wanted   = (door_state == DOOR_CLOSED) ? door_cfg.rc_open_code : door_cfg.rc_close_code;
        prev_cmd = last_rc_cmd;
      end else begin
        wanted   = (door_state == DOOR_CLOSED) ? APP_OPEN_CODE : APP_CLOSE_CODE;
        prev_cmd = last_app_cmd;
      end
      if (at_rest && prev_cmd == wanted && $urandom_range(3) != 0) cmd = cmd_t'($urandom);
      else if ($urandom_range(4) == 0) cmd = cmd_t'($urandom);
      else cmd = wanted;
    end
  endfunction

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch %s at result %0d: got %0h want %0h", what, outputs_checked,
               got_v, want_v);
  endtask

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic send_item(input op_t op, input cmd_t cmd);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.op      <= op;
    in_ch.command <= cmd;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    while (awaited_outputs.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  task automatic write_all_regs(input cfg_t c);
    cfg_word_t vals [7];
    // speed registers get junk in the upper byte
    vals = '{c.rc_open_code, c.rc_close_code, {8'($urandom), c.leaf_a_speed},
             {8'($urandom), c.leaf_b_speed}, c.open_ticks, c.close_ticks,
             c.flash_ticks};
    foreach (vals[i]) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_index <= REG_ORDER[i];
      cfg_wdata <= vals[i];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    door_cfg = c;
    settings_applied++;
  endtask

  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        want = advance_door(in_ch.op, in_ch.command);
        if (row_checked) want = row_expect;
        awaited_outputs.push_back(want);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.door_phase, out_ch.leaf_a_dir, out_ch.leaf_a_duty,
                out_ch.leaf_b_dir, out_ch.leaf_b_duty, out_ch.lift_drv_en,
                out_ch.leaf_b_drv_en, out_ch.small_lights, out_ch.big_lights_off};
        if (awaited_outputs.size() == 0) begin
          report_mismatch("result with none awaited", got, 0);
        end else begin
          want = awaited_outputs.pop_front();
          if (got.door_phase !== want.door_phase)
            report_mismatch("door_phase", got.door_phase, want.door_phase);
          if (got.leaf_a_dir !== want.leaf_a_dir)
            report_mismatch("leaf_a_dir", got.leaf_a_dir, want.leaf_a_dir);
          if (got.leaf_a_duty !== want.leaf_a_duty)
            report_mismatch("leaf_a_duty", got.leaf_a_duty, want.leaf_a_duty);
          if (got.leaf_b_dir !== want.leaf_b_dir)
            report_mismatch("leaf_b_dir", got.leaf_b_dir, want.leaf_b_dir);
          if (got.leaf_b_duty !== want.leaf_b_duty)
            report_mismatch("leaf_b_duty", got.leaf_b_duty, want.leaf_b_duty);
          if (got.lift_drv_en !== want.lift_drv_en)
            report_mismatch("lift_drv_en", got.lift_drv_en, want.lift_drv_en);
          if (got.leaf_b_drv_en !== want.leaf_b_drv_en)
            report_mismatch("leaf_b_drv_en", got.leaf_b_drv_en, want.leaf_b_drv_en);
          if (got.small_lights !== want.small_lights)
            report_mismatch("small_lights", got.small_lights, want.small_lights);
          if (got.big_lights_off !== want.big_lights_off)
            report_mismatch("big_lights_off", got.big_lights_off, want.big_lights_off);
        end
        outputs_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               awaited_outputs.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side backpressure, with one long hold on request
  initial begin : result_sink
    int held;
    held = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        held = LONG_HOLD;
      end
      if (held > 0) begin
        out_ch.ready <= 1'b0;
        held--;
      end else begin
        out_ch.ready <= 1'b1;
        held = gap_len();
      end
    end
  end

  initial begin : stimulus
    cfg_t settings;
    op_t  op;
    cmd_t cmd;
    cmd_t wanted;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    in_ch.valid   = 1'b0;
    in_ch.op      = OP_TICK;
    in_ch.command = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    write_all_regs(TABLE_CFG);
    idle_pct = 30;
    foreach (DIRECTED_STEPS[i]) begin
      row_checked = DIRECTED_STEPS[i].hand_checked;
      row_expect  = DIRECTED_STEPS[i].want;
      send_item(DIRECTED_STEPS[i].op, DIRECTED_STEPS[i].command);
    end
    row_checked = 1'b0;

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_for_results();
      settings = (ph == 1) ? ALL_ZERO : pick_settings();
      write_all_regs(settings);
      idle_pct = (ph == 0) ? 0 : $urandom_range(15, 45);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (ph == 2 && k == 40) long_hold_req = 1'b1;
        // let every result drain with no transfer offered
        if (ph == 3 && k == 80) wait_for_results();
        pick_item(op, cmd);
        send_item(op, cmd);
      end
    end

    // move at maximum settings: keeps driving through ticks and polls
    wait_for_results();
    write_all_regs(ALL_MAX);
    idle_pct = 0;
    while (door_state == DOOR_OPENED || door_state == DOOR_CLOSED) begin
      wanted = (door_state == DOOR_CLOSED) ? APP_OPEN_CODE : APP_CLOSE_CODE;
      send_item(OP_APP, (last_app_cmd == wanted) ? ~wanted : wanted);
    end
    for (int n = 0; n < MAX_RUN_TICKS; n++) begin
      send_item(OP_TICK, cmd_t'($urandom));
      if (n % 8 == 0) send_item(OP_RC, cmd_t'($urandom));
    end
    send_item(OP_APP, cmd_t'($urandom));
    send_item(OP_APP, cmd_t'($urandom));

    wait_for_results();
    $display("covered %0d items over %0d register settings, %0d results checked",
             items_sent, settings_applied, outputs_checked);
    $display("door moves finished %0d, light toggles %0d, last move driven at full settings",
             moves_done, toggles);
    if (mismatches == 0 && awaited_outputs.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
